### design/isr_pkg.sv
// Shared constants and types for the integer square root pipeline.
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

	// Fixed field widths of the stream beats.
	localparam int unsigned OPERAND_W = 64;
	localparam int unsigned ROOT_W    = 32;
	localparam int unsigned OUT_W     = 40;

	// Control bits that travel beside the data through every stage.
	typedef struct packed {
		logic valid;
		logic domain_error;
	} isr_ctl_t;

endpackage : isr_pkg

`default_nettype wire

### design/isr_step.sv
// One registered digit step of the restoring square root recurrence.
`timescale 1ns / 1ps
`default_nettype none

module isr_step #(
	parameter int unsigned WIDTH   = 64,
	parameter int unsigned BIT_POS = 62
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  isr_pkg::isr_ctl_t     ctl_in,
	input  wire  [WIDTH-1:0]      rem_in,
	input  wire  [WIDTH-1:0]      acc_in,
	output isr_pkg::isr_ctl_t     ctl_s,
	output logic [WIDTH-1:0]      rem_s,
	output logic [WIDTH-1:0]      acc_s
);
	import isr_pkg::*;

	localparam logic [WIDTH-1:0] BIT_VAL = WIDTH'(1) << BIT_POS;

	logic [WIDTH-1:0] trial;
	logic             take;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] acc_next;

	// The trial value acc + 4^k never overflows, since the operand reaching the
	// recurrence has its sign bit clear and acc grows no faster than its square root.
	always_comb begin
		trial    = acc_in + BIT_VAL;
		take     = (rem_in >= trial);
		rem_next = take ? (rem_in - trial) : rem_in;
		acc_next = take ? ((acc_in >> 1) + BIT_VAL) : (acc_in >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (en) begin
			ctl_s <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s <= rem_next;
			acc_s <= acc_next;
		end
	end

endmodule : isr_step

`default_nettype wire

### design/integer_square_root_unit.sv
// Top level of the pipelined integer square root unit.
//
//   Port group | Dir | Beat contents (lowest bit first)
//   s_*        | in  | tdata[63:0]: operand (signed, low DATA_WIDTH bits used)
//   m_*        | out | tdata[31:0]: root, tdata[32]: domain_error, rest zero
//
// One input register, then one stage per root bit: DATA_WIDTH/2 stages, each a
// single subtract-and-compare. A new beat enters every cycle while the output side
// takes beats. Reset clears only the control bits (valid and domain_error); the
// data path needs none. A stall on the output freezes the whole pipeline, so
// nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module integer_square_root_unit #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [isr_pkg::OPERAND_W-1:0] s_tdata,  // [63:0] operand
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [isr_pkg::OUT_W-1:0]    m_tdata    // [31:0] root, [32] domain_error
);
	import isr_pkg::*;

	localparam int unsigned STEPS   = (DATA_WIDTH - 2) / 2 + 1;
	localparam int unsigned TOP_POS = ((DATA_WIDTH - 2) / 2) * 2;

	logic                  en;
	isr_ctl_t              ctl_p [0:STEPS];
	logic [DATA_WIDTH-1:0] rem_p [0:STEPS];
	logic [DATA_WIDTH-1:0] acc_p [0:STEPS];

	isr_ctl_t              ctl_s1;
	logic [DATA_WIDTH-1:0] rem_s1;
	logic [DATA_WIDTH-1:0] value;
	logic                  negative;

	// The pipeline moves as one; it holds only when a finished beat waits.
	assign en       = !ctl_p[STEPS].valid || m_tready;
	assign s_tready = en;

	assign value    = s_tdata[DATA_WIDTH-1:0];
	assign negative = value[DATA_WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid        <= s_tvalid;
			ctl_s1.domain_error <= negative;
		end
	end

	// A negative operand starts from zero, which makes the root come out zero.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= negative ? '0 : value;
		end
	end

	assign ctl_p[0] = ctl_s1;
	assign rem_p[0] = rem_s1;
	assign acc_p[0] = '0;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		isr_step #(
			.WIDTH   (DATA_WIDTH),
			.BIT_POS (TOP_POS - 2 * i)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_p[i]),
			.rem_in (rem_p[i]),
			.acc_in (acc_p[i]),
			.ctl_s  (ctl_p[i+1]),
			.rem_s  (rem_p[i+1]),
			.acc_s  (acc_p[i+1])
		);
	end

	logic [ROOT_W-1:0] root;

	assign root     = ROOT_W'(acc_p[STEPS]);
	assign m_tvalid = ctl_p[STEPS].valid;
	assign m_tdata  = {(OUT_W - ROOT_W - 1)'(0), ctl_p[STEPS].domain_error, root};

	// A domain error always comes with a zero root.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[ROOT_W]) |-> (m_tdata[ROOT_W-1:0] == '0))
		else $error("domain error beat carries a nonzero root");

	// The root never has more bits than there are digit steps.
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((33'(m_tdata[ROOT_W-1:0]) >> STEPS) == '0))
		else $error("root exceeds the digit count");

	// The input side only stalls behind a held output beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

endmodule : integer_square_root_unit

`default_nettype wire

### tb/integer_square_root_unit_test.sv
// Stream-level testbench for the pipelined integer square root unit.
`timescale 1ns / 1ps

module integer_square_root_unit_test;
	import isr_pkg::*;

	localparam int unsigned DATA_WIDTH   = 64;
	localparam int unsigned LATENCY      = DATA_WIDTH / 2 + 1;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned IDLE_PERCENT = 13;
	localparam int unsigned MAX_ROOT     = 32'd3037000499;

	// One output beat as it appears on m_tdata, lowest field last.
	typedef struct packed {
		logic [OUT_W-ROOT_W-2:0] pad;
		logic                    domain_error;
		logic [ROOT_W-1:0]       root;
	} root_beat_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [OPERAND_W-1:0] s_tdata  = '0;  // [63:0] operand
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;        // [31:0] root, [32] domain_error, rest zero

	root_beat_t  pending_roots[$];
	logic        steady_flow     = 1'b0;
	int unsigned mismatch_count  = 0;
	int unsigned roots_checked   = 0;
	int unsigned operands_sent   = 0;
	int unsigned negatives_sent  = 0;
	int unsigned quiet_cycles    = 0;

	integer_square_root_unit #(
		.DATA_WIDTH(DATA_WIDTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Restoring digit recurrence over powers of four, on the low DATA_WIDTH bits.
	function automatic root_beat_t predict_root(input logic [OPERAND_W-1:0] operand);
		logic [63:0] value;
		logic [63:0] remainder;
		logic [63:0] acc;
		logic [63:0] weight;
		root_beat_t  beat;
		value = operand & ({64{1'b1}} >> (64 - DATA_WIDTH));
		beat = '0;
		beat.domain_error = value[DATA_WIDTH-1];
		if (!beat.domain_error && value != 0) begin
			remainder = value;
			acc = '0;
			weight = 64'd1 << ((DATA_WIDTH - 2) & ~1);
			while (weight > remainder)
				weight = weight >> 2;
			while (weight != 0) begin
				if (remainder >= acc + weight) begin
					remainder = remainder - (acc + weight);
					acc = acc + (weight << 1);
				end
				acc = acc >> 1;
				weight = weight >> 2;
			end
			beat.root = acc[ROOT_W-1:0];
		end
		return beat;
	endfunction

	// Drives one operand beat from a falling edge and returns at the falling edge
	// after it was taken; under steady_flow, back-to-back calls keep s_tvalid high.
	task automatic send_operand(input logic [OPERAND_W-1:0] operand);
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = operand;
		do
			@(posedge clk);
		while (!s_tready);
		pending_roots.push_back(predict_root(operand));
		operands_sent++;
		if (operand[DATA_WIDTH-1])
			negatives_sent++;
		@(negedge clk);
	endtask

	task automatic test_corner_operands();
		logic [63:0] corner_operands [0:22];
		corner_operands = '{
			64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd8, 64'd15, 64'd16, 64'd17,
			64'd99, 64'd100,
			64'h3FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF,
			64'd9223372030926249001, 64'd9223372030926249000,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000,
			64'h0000_0001_0000_0000,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
		};
		foreach (corner_operands[i])
			send_operand(corner_operands[i]);
	endtask

	task automatic test_full_range(input int unsigned count);
		repeat (count)
			send_operand({$urandom, $urandom});
	endtask

	// Operands with a random bit length, so every starting power of four is used.
	task automatic test_operand_lengths(input int unsigned count);
		logic [63:0] value;
		int unsigned length;
		repeat (count) begin
			length = $urandom_range(1, DATA_WIDTH);
			value = {$urandom, $urandom} >> (64 - length);
			value[length-1] = 1'b1;
			send_operand(value);
		end
	endtask

	// Perfect squares and their neighbors sit exactly at the boundary between two roots.
	task automatic test_near_squares(input int unsigned count);
		logic [63:0] base;
		logic [63:0] square;
		repeat (count) begin
			base = 64'($urandom_range(0, MAX_ROOT) >> $urandom_range(0, 31));
			square = base * base;
			case ($urandom_range(0, 3))
				0: send_operand(square - 64'd1);
				1: send_operand(square);
				2: send_operand(square + 64'd1);
				default: send_operand(square + (base << 1));
			endcase
		end
	endtask

	task automatic test_steady_stream(input int unsigned count);
		steady_flow = 1'b1;
		test_operand_lengths(count / 2);
		test_near_squares(count - count / 2);
		steady_flow = 1'b0;
	endtask

	always @(negedge clk)
		m_tready = steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);

	always @(posedge clk) begin
		root_beat_t got;
		root_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = root_beat_t'(m_tdata);
			if (pending_roots.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_roots.pop_front();
				roots_checked++;
				if (got.root !== want.root) begin
					$display("%0t: root mismatch, expected %0d, got %0d",
						$time, want.root, got.root);
					mismatch_count++;
				end
				if (got.domain_error !== want.domain_error) begin
					$display("%0t: domain_error mismatch, expected %b, got %b",
						$time, want.domain_error, got.domain_error);
					mismatch_count++;
				end
				if (got.pad !== want.pad) begin
					$display("%0t: padding mismatch, expected %h, got %h",
						$time, want.pad, got.pad);
					mismatch_count++;
				end
			end
		end
	end

	// Any cycle without a beat on either side counts toward the timeout.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_operands();
		test_full_range(350);
		test_operand_lengths(350);
		test_near_squares(350);
		test_steady_stream(180);
		s_tvalid = 1'b0;

		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("Sent %0d operands, %0d of them negative, and checked %0d roots.",
			operands_sent, negatives_sent, roots_checked);
		$display("Traffic covered corner values, full-range, length-swept, near-square "
			, "and back-to-back operands.");
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
